### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/mbup_pkg.sv
// ----------------------------------------------------------------------------
// mbup_pkg
// Types and constants for the MIDI byte to USB-MIDI packet core.
// ----------------------------------------------------------------------------
package mbup_pkg;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_CABLE  = 2'd0;
  localparam logic [1:0] REG_COMMON = 2'd1;
  localparam logic [1:0] REG_SYSTEM = 2'd2;

  localparam logic [3:0]  CABLE_RST  = 4'd0;
  localparam logic [15:0] COMMON_RST = 16'h25AA;
  localparam logic [31:0] SYSTEM_RST = 32'h0000_0064;

  // MIDI status bytes
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  // code index numbers
  localparam logic [3:0] CIN_SYS_2BYTE = 4'h2;
  localparam logic [3:0] CIN_SYS_3BYTE = 4'h3;
  localparam logic [3:0] CIN_SYSEX     = 4'h4;
  localparam logic [3:0] CIN_END_1     = 4'h5;
  localparam logic [3:0] CIN_END_2     = 4'h6;
  localparam logic [3:0] CIN_END_3     = 4'h7;
  localparam logic [3:0] CIN_REALTIME  = 4'hF;

  typedef struct packed {
    logic [7:0] cur_status;
    logic [1:0] expected_count;
    logic [7:0] remaining_count;
    logic [1:0] sysex_position;
    logic [7:0] held_first;
    logic [7:0] held_second;
    logic [7:0] held_third;
  } parse_state_t;

  typedef struct packed {
    logic [3:0]  cable_number;
    logic [15:0] common_length_table;
    logic [31:0] system_length_table;
  } cfg_regs_t;

  // packed as on the wire: header in the lowest byte
  typedef struct packed {
    logic [7:0] event_byte_three;
    logic [7:0] event_byte_two;
    logic [7:0] event_byte_one;
    logic [7:0] header_byte;
  } usb_packet_t;

endpackage

### src/midi_byte_to_usb_packet_core.sv
// ----------------------------------------------------------------------------
// midi_byte_to_usb_packet_core
// Serial MIDI byte stream in, USB-MIDI 4-byte event packets out.
// ----------------------------------------------------------------------------
// Takes one MIDI byte per clock and emits zero or one USB-MIDI event packet
// per byte. A byte is registered in the stage register at its input transfer,
// parsed there against the running status, and its packet (if any) is loaded
// into the output register when the staged byte retires. Throughput is one
// byte per cycle; the input only stalls when a byte that makes a packet finds
// the output register still held by the sink.
// Length tables and the cable number come from the APB registers (0x0 cable,
// 0x4 common-message lengths, 0x8 system-message lengths) and must only be
// written while the stream is idle.
module midi_byte_to_usb_packet_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] midi_byte
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] header_byte, [15:8] event_byte_one,
                                  // [23:16] event_byte_two, [31:24] event_byte_three
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mbup_pkg::*;

  cfg_regs_t    cfg_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  usb_packet_t  packet;
  usb_packet_t  out_data_r;
  logic         emit;
  logic         stage_v_r;
  logic [7:0]   stage_byte_r;
  logic         out_v_r;
  logic         out_free;
  logic         stage_go;
  logic         in_xfer;
  logic         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cable_number        <= CABLE_RST;
      cfg_r.common_length_table <= COMMON_RST;
      cfg_r.system_length_table <= SYSTEM_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_CABLE:  cfg_r.cable_number        <= cfg_pwdata[3:0];
        REG_COMMON: cfg_r.common_length_table <= cfg_pwdata[15:0];
        REG_SYSTEM: cfg_r.system_length_table <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_CABLE:  cfg_prdata = {28'd0, cfg_r.cable_number};
      REG_COMMON: cfg_prdata = {16'd0, cfg_r.common_length_table};
      REG_SYSTEM: cfg_prdata = cfg_r.system_length_table;
      default:    cfg_prdata = 32'd0;
    endcase
  end

  mbup_step u_step (
    .midi_byte (stage_byte_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .emit      (emit),
    .packet    (packet)
  );

  // a staged byte retires unless it makes a packet and the output is held
  assign out_free  = !out_v_r || out_tready;
  assign stage_go  = stage_v_r && (!emit || out_free);
  assign in_tready = !stage_v_r || stage_go;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      out_v_r   <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_xfer) begin
        stage_v_r <= 1'b1;
      end else if (stage_go) begin
        stage_v_r <= 1'b0;
      end
      if (stage_go) begin
        state_r <= state_nxt;
      end
      if (stage_go && emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_byte_r <= in_tdata;
    end
    if (stage_go && emit) begin
      out_data_r <= packet;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

### src/mbup_step.sv
// ----------------------------------------------------------------------------
// mbup_step
// Parser step: next parser state and the optional event packet for one byte.
// ----------------------------------------------------------------------------
module mbup_step (
  input  logic [7:0]            midi_byte,
  input  mbup_pkg::cfg_regs_t   cfg,
  input  mbup_pkg::parse_state_t state,
  output mbup_pkg::parse_state_t state_nxt,
  output logic                  emit,
  output mbup_pkg::usb_packet_t packet
);
  import mbup_pkg::*;

  logic [3:0] code;
  logic [7:0] b1, b2, b3;
  logic [1:0] common_cnt;
  logic [1:0] system_cnt;
  logic [1:0] pos_inc;
  logic [7:0] rem_nxt;

  assign common_cnt = cfg.common_length_table[{midi_byte[6:4], 1'b0} +: 2];
  assign system_cnt = cfg.system_length_table[{midi_byte[3:0], 1'b0} +: 2];
  assign pos_inc    = state.sysex_position + 2'd1;
  assign rem_nxt    = (state.remaining_count == 8'd0) ?
                      ({6'd0, state.expected_count} - 8'd1) :
                      (state.remaining_count - 8'd1);

  always_comb begin
    state_nxt = state;
    emit      = 1'b0;
    code      = CIN_REALTIME;
    b1        = 8'd0;
    b2        = 8'd0;
    b3        = 8'd0;

    if (midi_byte[7]) begin
      if (midi_byte[7:3] == 5'b11111) begin
        // realtime: straight through, running status untouched
        emit = 1'b1;
        code = CIN_REALTIME;
        b1   = midi_byte;
      end else begin
        state_nxt.cur_status     = midi_byte;
        state_nxt.expected_count = common_cnt;
        if (common_cnt == 2'd0) begin
          state_nxt.expected_count = system_cnt;
          if (midi_byte == SYSEX_START) begin
            state_nxt.held_first     = SYSEX_START;
            state_nxt.sysex_position = 2'd1;
          end else if (midi_byte == SYSEX_END) begin
            emit = 1'b1;
            case (state.sysex_position)
              2'd0: begin
                code = CIN_END_1;
                b1   = SYSEX_END;
              end
              2'd1: begin
                code = CIN_END_2;
                b1   = state.held_first;
                b2   = SYSEX_END;
              end
              default: begin
                code = CIN_END_3;
                b1   = state.held_first;
                b2   = state.held_second;
                b3   = SYSEX_END;
              end
            endcase
            state_nxt.sysex_position = 2'd0;
          end
        end
        state_nxt.remaining_count = {6'd0, state_nxt.expected_count};
      end
    end else if (state.cur_status == SYSEX_START) begin
      state_nxt.sysex_position = pos_inc;
      if (pos_inc == 2'd1) begin
        state_nxt.held_first = midi_byte;
      end else if (pos_inc == 2'd2) begin
        state_nxt.held_second = midi_byte;
      end else begin
        state_nxt.held_third     = midi_byte;
        state_nxt.sysex_position = 2'd0;
        emit = 1'b1;
        code = CIN_SYSEX;
        b1   = state.held_first;
        b2   = state.held_second;
        b3   = midi_byte;
      end
    end else begin
      state_nxt.remaining_count = rem_nxt;
      if (state.expected_count == 2'd1) begin
        state_nxt.held_second = midi_byte;
        state_nxt.held_third  = 8'd0;
      end else if (rem_nxt == 8'd0) begin
        state_nxt.held_third = midi_byte;
      end else begin
        state_nxt.held_second = midi_byte;
      end

      if (rem_nxt == 8'd0) begin
        emit = 1'b1;
        if (state.cur_status[7:4] != 4'hF) begin
          code = state.cur_status[7:4];
        end else if (state.expected_count == 2'd0) begin
          code = CIN_END_1;
        end else if (state.expected_count == 2'd1) begin
          code = CIN_SYS_2BYTE;
        end else begin
          code = CIN_SYS_3BYTE;
        end
        b1 = state.cur_status;
        b2 = state_nxt.held_second;
        b3 = state_nxt.held_third;
      end
    end

    packet.header_byte      = {cfg.cable_number, code};
    packet.event_byte_one   = b1;
    packet.event_byte_two   = b2;
    packet.event_byte_three = b3;
  end

endmodule

### src/mbup_checker.sv
// ----------------------------------------------------------------------------
// mbup_checker
// Port-level checks for the MIDI to USB-MIDI packet core, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbup_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import mbup_pkg::*;

  logic out_stall;
  logic rt_pkt;
  logic rt_ok;

  assign out_stall = out_tvalid && !out_tready;
  assign rt_pkt    = out_tvalid && (out_tdata[3:0] == CIN_REALTIME);
  assign rt_ok     = (out_tdata[15:11] == 5'h1F) && (out_tdata[31:16] == 16'h0);

  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  `ASSERT_RST(a_hold_valid, clk, rst_n, out_stall |=> out_tvalid, "valid dropped")

  `ASSERT_RST(a_hold_data, clk, rst_n, out_stall |=> $stable(out_tdata), "data moved")

  // code 15 only carries a lone realtime byte
  `ASSERT_RST(a_realtime, clk, rst_n, rt_pkt |-> rt_ok, "bad realtime packet")

endmodule

bind midi_byte_to_usb_packet_core mbup_checker u_mbup_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for midi_byte_to_usb_packet_core.
// ----------------------------------------------------------------------------
// Serial MIDI bytes go in over the input stream. A local parser model
// predicts every USB-MIDI event packet, and the packets that come out are
// compared field by field in order. The run covers directed message
// sequences, length table and cable extremes, a long sink hold-off, random
// message streams under several register settings, and a final stretch
// without idling.
module tb_top;
  import mbup_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;    // [7:0] midi_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [7:0] header, [15:8] byte one, [23:16] byte two,
                                    // [31:24] byte three
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  midi_byte_to_usb_packet_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (psel),
    .cfg_penable (penable),
    .cfg_pwrite  (pwrite),
    .cfg_paddr   (paddr),
    .cfg_pwdata  (pwdata),
    .cfg_prdata  (prdata),
    .cfg_pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  logic [3:0]  mirror_cable = CABLE_RST;
  logic [15:0] mirror_common = COMMON_RST;
  logic [31:0] mirror_system = SYSTEM_RST;

  // parser mirror
  logic [7:0] run_status = 8'h00;
  logic [7:0] exp_count = 8'h00;
  logic [7:0] rem_count = 8'h00;
  logic [1:0] sx_pos = 2'd0;
  logic [7:0] held1 = 8'h00;
  logic [7:0] held2 = 8'h00;
  logic [7:0] held3 = 8'h00;

  usb_packet_t pending_packets [$];
  int mismatch_count = 0;
  int items_sent = 0;
  logic [7:0] gen_status = 8'h00;

  bit tx_random = 1'b1;
  bit rx_random = 1'b1;
  bit hold_go = 1'b0;
  logic hold_active = 1'b0;
  int rx_gap = 0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %02h want %02h", what, got, want);
    mismatch_count++;
  endtask

  task automatic push_packet(input logic [3:0] code, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    usb_packet_t p;
    p.header_byte      = {mirror_cable, code};
    p.event_byte_one   = b1;
    p.event_byte_two   = b2;
    p.event_byte_three = b3;
    pending_packets.push_back(p);
  endtask

  task automatic predict_packet(input logic [7:0] b);
    logic [3:0] code;
    if (b[7]) begin
      if (b >= 8'hF8) begin
        push_packet(CIN_REALTIME, b, 8'h00, 8'h00);
      end else begin
        run_status = b;
        exp_count = {6'd0, mirror_common[{b[6:4], 1'b0} +: 2]};
        if (exp_count == 8'd0) begin
          exp_count = {6'd0, mirror_system[{b[3:0], 1'b0} +: 2]};
          if (b == SYSEX_START) begin
            held1 = SYSEX_START;
            sx_pos = 2'd1;
          end else if (b == SYSEX_END) begin
            if (sx_pos == 2'd0)
              push_packet(CIN_END_1, SYSEX_END, 8'h00, 8'h00);
            else if (sx_pos == 2'd1)
              push_packet(CIN_END_2, held1, SYSEX_END, 8'h00);
            else
              push_packet(CIN_END_3, held1, held2, SYSEX_END);
            sx_pos = 2'd0;
          end
        end
        rem_count = exp_count;
      end
    end else if (run_status == SYSEX_START) begin
      sx_pos = sx_pos + 2'd1;
      if (sx_pos == 2'd1) begin
        held1 = b;
      end else if (sx_pos == 2'd2) begin
        held2 = b;
      end else begin
        held3 = b;
        push_packet(CIN_SYSEX, held1, held2, held3);
        sx_pos = 2'd0;
      end
    end else begin
      // zero remaining means a new message starts (counts wrap at 8 bits)
      if (rem_count == 8'd0)
        rem_count = exp_count - 8'd1;
      else
        rem_count = rem_count - 8'd1;
      if (exp_count == 8'd1) begin
        held2 = b;
        held3 = 8'h00;
      end else if (rem_count == 8'd0) begin
        held3 = b;
      end else begin
        held2 = b;
      end
      if (rem_count == 8'd0) begin
        if (run_status[7:4] != 4'hF)
          code = run_status[7:4];
        else if (exp_count == 8'd0)
          code = CIN_END_1;
        else if (exp_count == 8'd1)
          code = CIN_SYS_2BYTE;
        else
          code = CIN_SYS_3BYTE;
        push_packet(code, run_status, held2, held3);
      end
    end
  endtask

  // sink side: random ready bursts, plus the long hold-off when requested
  always @(posedge clk) begin
    if (hold_active) begin
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      out_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (rx_random && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      rx_gap <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    forever begin
      wait (hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
      wait (!hold_go);
    end
  end

  always @(posedge clk) begin
    usb_packet_t got;
    usb_packet_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_packets.size() == 0) begin
        report_mismatch("unexpected packet, header", got.header_byte, 8'h00);
      end else begin
        want = pending_packets.pop_front();
        if (got.header_byte != want.header_byte)
          report_mismatch("header_byte", got.header_byte, want.header_byte);
        if (got.event_byte_one != want.event_byte_one)
          report_mismatch("event_byte_one", got.event_byte_one, want.event_byte_one);
        if (got.event_byte_two != want.event_byte_two)
          report_mismatch("event_byte_two", got.event_byte_two, want.event_byte_two);
        if (got.event_byte_three != want.event_byte_three)
          report_mismatch("event_byte_three", got.event_byte_three, want.event_byte_three);
      end
    end
  end

  // valid stays high between back-to-back bytes; drain_stream lowers it
  task automatic send_byte(input logic [7:0] b);
    if (tx_random && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    predict_packet(b);
    items_sent++;
  endtask

  task automatic drain_stream();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_packets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CABLE:  mirror_cable = val[3:0];
      REG_COMMON: mirror_common = val[15:0];
      REG_SYSTEM: mirror_system = val;
      default: ;
    endcase
  endtask

  task automatic send_data(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_byte(8'($urandom_range(8'hF8, 8'hFF)));
      send_byte(8'($urandom_range(0, 127)));
    end
  endtask

  // one random message; mostly well formed, some noise and truncated SysEx
  task automatic send_message();
    int pick;
    int cnt;
    logic [7:0] st;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if (gen_status >= 8'h80 && gen_status < 8'hF0 && $urandom_range(0, 2) == 0) begin
        st = gen_status;
      end else begin
        st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
        send_byte(st);
      end
      gen_status = st;
      cnt = int'(mirror_common[{st[6:4], 1'b0} +: 2]);
      if (cnt == 0)
        cnt = $urandom_range(0, 2);
      send_data(cnt);
    end else if (pick < 65) begin
      gen_status = SYSEX_START;
      send_byte(SYSEX_START);
      send_data($urandom_range(0, 10));
      if ($urandom_range(0, 9) != 0)
        send_byte(SYSEX_END);
    end else if (pick < 78) begin
      st = {4'hF, 4'($urandom_range(1, 6))};
      gen_status = st;
      send_byte(st);
      send_data(int'(mirror_system[{st[3:0], 1'b0} +: 2]));
    end else if (pick < 88) begin
      send_byte(8'($urandom_range(8'hF8, 8'hFF)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_messages(input int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) send_message();
  endtask

  // reset tables: note, running status, program change, realtime, all SysEx
  // endings, system common with one and two data bytes, data before status
  task automatic test_directed();
    logic [7:0] seq [$] = '{8'h00, 8'h90, 8'h3C, 8'h7F, 8'h40, 8'h00, 8'hC5, 8'h7F,
                            8'hF8, 8'hFF, 8'hF0, 8'h01, 8'h02, 8'h03, 8'h04, 8'hF7,
                            8'hF0, 8'h11, 8'h22, 8'hF7, 8'hF7, 8'hF2, 8'h10, 8'h20,
                            8'hF3, 8'h05, 8'hF6, 8'h55};
    foreach (seq[i]) send_byte(seq[i]);
    drain_stream();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_CABLE, 32'hF);
    write_reg(REG_COMMON, 32'h0);
    write_reg(REG_SYSTEM, 32'h0);
    run_messages(30);
    drain_stream();
    write_reg(REG_CABLE, 32'h0);
    write_reg(REG_COMMON, 32'hFFFF);
    write_reg(REG_SYSTEM, 32'hFFFF_FFFF);
    run_messages(30);
    drain_stream();
  endtask

  // sink holds off while realtime bytes keep coming, so the core stalls input
  task automatic test_backpressure();
    write_reg(REG_CABLE, 32'($urandom_range(0, 15)));
    write_reg(REG_COMMON, 32'(COMMON_RST));
    write_reg(REG_SYSTEM, SYSTEM_RST);
    hold_go = 1'b1;
    for (int i = 0; i < 40; i++)
      send_byte(8'($urandom_range(8'hF8, 8'hFF)));
    hold_go = 1'b0;
    drain_stream();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_CABLE, 32'($urandom_range(0, 15)));
      if (ph == 0) begin
        write_reg(REG_COMMON, 32'(COMMON_RST));
        write_reg(REG_SYSTEM, SYSTEM_RST);
      end else begin
        write_reg(REG_COMMON, 32'($urandom_range(0, 16'hFFFF)));
        write_reg(REG_SYSTEM, $urandom);
      end
      run_messages(50);
      drain_stream();   // sender waits for every packet mid-phase
      run_messages(50);
      drain_stream();
    end
  endtask

  task automatic test_no_idle();
    tx_random = 1'b0;
    rx_random = 1'b0;
    write_reg(REG_CABLE, 32'($urandom_range(0, 15)));
    write_reg(REG_COMMON, 32'(COMMON_RST));
    write_reg(REG_SYSTEM, SYSTEM_RST);
    run_messages(60);
    drain_stream();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_phases();
    test_no_idle();
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
